// ----- sv/wrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and neighbor addressing for the water ripple height map.
package wrp_pkg;

   localparam int GRID_WIDTH  = 14;
   localparam int GRID_HEIGHT = 5;
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int X_W         = $clog2(GRID_WIDTH);
   localparam int Y_W         = $clog2(GRID_HEIGHT);
   localparam int ADDR_W      = CELL_W + 1;
   localparam int DEPTH       = 2 ** ADDR_W;
   localparam int SUM_W       = 11;
   localparam int STEP_W      = 3;

   localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

   localparam logic [2:0] MODE_PRESS = 3'd0;
   localparam logic [2:0] MODE_DROP  = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_FLIP  = 3'd4;

   localparam logic [7:0] PRESS_LEVEL = 8'h7f;
   localparam logic [7:0] DROP_RING   = 8'h60;

   localparam logic [0:0] REG_RAINBOW   = 1'b0;
   localparam logic [0:0] REG_FIXED_HUE = 1'b1;

   // neighbor offsets, row above, same row, row below
   localparam int NBR_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
   localparam int NBR_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

   typedef struct packed {
      logic latch;
      logic hue_inc;
      logic flip;
      logic press_wr;
      logic drop_wr;
      logic rd_issue;
      logic out_load;
      logic wave_rd;
      logic wave_wr;
   } wrp_cmd_type;

   typedef struct packed {
      logic step_last;
      logic cell_last;
      logic out_free;
   } wrp_status_type;

   // cell number of neighbor k of (x, y), coordinates clamped to the grid
   function automatic logic [CELL_W-1:0] nbr_cell(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                                 logic [2:0] k);
      int nx;
      int ny;
      nx = int'(x) + NBR_DX[k];
      ny = int'(y) + NBR_DY[k];
      if (nx < 0) nx = 0;
      if (nx > GRID_WIDTH - 1) nx = GRID_WIDTH - 1;
      if (ny < 0) ny = 0;
      if (ny > GRID_HEIGHT - 1) ny = GRID_HEIGHT - 1;
      return CELL_W'(ny * GRID_WIDTH + nx);
   endfunction

endpackage

// ----- sv/wrp_csr.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module wrp_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        rainbow_enable,
   output logic [7:0]  fixed_hue
);

   logic       rainbow_ff;
   logic       rainbow_in;
   logic [7:0] fixed_hue_ff;
   logic [7:0] fixed_hue_in;
   logic       wr_en;
   logic [0:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[2];

   always_comb begin
      rainbow_in   = rainbow_ff;
      fixed_hue_in = fixed_hue_ff;
      if (wr_en) begin
         case (reg_idx)
            wrp_pkg::REG_RAINBOW:   rainbow_in   = pwdata[0];
            wrp_pkg::REG_FIXED_HUE: fixed_hue_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rainbow_ff   <= 1'b1;
         fixed_hue_ff <= 8'd0;
      end else begin
         rainbow_ff   <= rainbow_in;
         fixed_hue_ff <= fixed_hue_in;
      end
   end

   always_comb begin
      case (reg_idx)
         wrp_pkg::REG_RAINBOW:   prdata = {31'd0, rainbow_ff};
         wrp_pkg::REG_FIXED_HUE: prdata = {24'd0, fixed_hue_ff};
         default:                prdata = 32'd0;
      endcase
   end

   assign rainbow_enable = rainbow_ff;
   assign fixed_hue      = fixed_hue_ff;

endmodule

// ----- sv/wrp_ctrl.sv -----
`timescale 1ns / 1ps
// Item sequencer: press, raindrop, read, flip, tick and the wave sweep.
module wrp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [2:0]              req_mode,
   input  logic                    req_run_water,
   output logic                    req_stall,
   input  wrp_pkg::wrp_status_type status,
   output wrp_pkg::wrp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PRESS    = 3'd1;
   localparam logic [2:0] S_DROP     = 3'd2;
   localparam logic [2:0] S_RD_ISSUE = 3'd3;
   localparam logic [2:0] S_RD_WAIT  = 3'd4;
   localparam logic [2:0] S_WAVE_RD  = 3'd5;
   localparam logic [2:0] S_WAVE_WR  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               case (req_mode)
                  wrp_pkg::MODE_PRESS: state_in = S_PRESS;
                  wrp_pkg::MODE_DROP:  state_in = S_DROP;
                  wrp_pkg::MODE_TICK: begin
                     cmd.hue_inc = 1'b1;
                     if (req_run_water) state_in = S_WAVE_RD;
                  end
                  wrp_pkg::MODE_READ:  state_in = S_RD_ISSUE;
                  wrp_pkg::MODE_FLIP:  cmd.flip = 1'b1;
                  default: ;
               endcase
            end
         end
         S_PRESS: begin
            cmd.press_wr = 1'b1;
            state_in     = S_IDLE;
         end
         S_DROP: begin
            cmd.drop_wr = 1'b1;
            if (status.step_last) state_in = S_IDLE;
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WAVE_RD: begin
            cmd.wave_rd = 1'b1;
            if (status.step_last) state_in = S_WAVE_WR;
         end
         S_WAVE_WR: begin
            cmd.wave_wr = 1'b1;
            state_in    = status.cell_last ? S_IDLE : S_WAVE_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- sv/wrp_datapath.sv -----
`timescale 1ns / 1ps
// Height page memory, wave arithmetic, color terms and the result register.
module wrp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  wrp_pkg::wrp_cmd_type    cmd,
   output wrp_pkg::wrp_status_type status,
   input  logic [6:0]              req_cell_index,
   input  logic [3:0]              req_col,
   input  logic [2:0]              req_row,
   input  logic                    req_blend,
   input  logic                    rainbow_enable,
   input  logic [7:0]              fixed_hue,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic signed [7:0]       rsp_height,
   output logic [7:0]              rsp_intensity,
   output logic [7:0]              rsp_saturation,
   output logic [7:0]              rsp_brightness,
   output logic [7:0]              rsp_hue
);

   localparam int CW = wrp_pkg::CELL_W;
   localparam int XW = wrp_pkg::X_W;
   localparam int YW = wrp_pkg::Y_W;
   localparam int AW = wrp_pkg::ADDR_W;
   localparam int SW = wrp_pkg::SUM_W;
   localparam logic [CW-1:0] W_C = CW'(wrp_pkg::GRID_WIDTH);

   // raindrop write order
   localparam logic [2:0] DROP_CENTER = 3'd0;
   localparam logic [2:0] DROP_UP     = 3'd1;
   localparam logic [2:0] DROP_DOWN   = 3'd2;
   localparam logic [2:0] DROP_LEFT   = 3'd3;
   localparam logic [2:0] DROP_RIGHT  = 3'd4;

   // latched item
   logic [6:0] cell_ff;
   logic [3:0] col_ff;
   logic [2:0] row_ff;
   logic       blend_ff;

   logic       front_ff, front_in;
   logic [7:0] hue_cnt_ff, hue_cnt_in;

   logic [wrp_pkg::STEP_W-1:0] step_ff, step_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [SW-1:0] acc_ff, acc_in;

   // page memory, both pages, address = {page, cell}
   logic [7:0] page_mem_ff [wrp_pkg::DEPTH];
   logic [wrp_pkg::DEPTH-1:0] vld_ff;
   logic [7:0] rd_a_raw_ff, rd_b_raw_ff;
   logic       rd_a_vld_ff, rd_b_vld_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_a_addr, rd_b_addr;

   logic          cell_ok;
   logic          drop_ok;
   logic [CW-1:0] spot;

   logic signed [7:0]    rd_a_s, rd_b_s;
   logic signed [SW-1:0] quarter, wave_v, wave_r;
   logic signed [8:0]    blend_sum;
   logic signed [8:0]    blend_half;
   logic signed [7:0]    h, half_h;
   logic [7:0]           mag, inten, sat, bright, hue;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] height_ff;
   logic [7:0] inten_ff, sat_ff, bright_ff, hue_ff;

   assign cell_ok = (cell_ff < 7'(wrp_pkg::CELLS));
   assign drop_ok = (32'(col_ff) < wrp_pkg::GRID_WIDTH) && (32'(row_ff) < wrp_pkg::GRID_HEIGHT);
   assign spot    = CW'(32'(row_ff) * wrp_pkg::GRID_WIDTH + 32'(col_ff));

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cell_ff  <= req_cell_index;
         col_ff   <= req_col;
         row_ff   <= req_row;
         blend_ff <= req_blend;
      end
   end

   // sequencing counters
   always_comb begin
      front_in   = cmd.flip ? !front_ff : front_ff;
      hue_cnt_in = cmd.hue_inc ? hue_cnt_ff + 8'd1 : hue_cnt_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      if (cmd.latch) begin
         step_in = '0;
         x_in    = '0;
         y_in    = '0;
         cnt_in  = '0;
      end else begin
         if (cmd.drop_wr || cmd.wave_rd)
            step_in = (step_ff == wrp_pkg::STEP_LAST) ? '0 : step_ff + 1'b1;
         if (cmd.wave_wr) begin
            cnt_in = cnt_ff + 1'b1;
            if (x_ff == XW'(wrp_pkg::GRID_WIDTH - 1)) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= 1'b0;
         hue_cnt_ff <= 8'd0;
         step_ff    <= '0;
      end else begin
         front_ff   <= front_in;
         hue_cnt_ff <= hue_cnt_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
   end

   assign status.step_last = (step_ff == wrp_pkg::STEP_LAST);
   assign status.cell_last = (cnt_ff == CW'(wrp_pkg::CELLS - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // read data, an entry never written reads as zero
   assign rd_a_s = $signed(rd_a_vld_ff ? rd_a_raw_ff : 8'd0);
   assign rd_b_s = $signed(rd_b_vld_ff ? rd_b_raw_ff : 8'd0);

   // wave arithmetic; back cell arrives in the write cycle on port a
   always_comb begin
      acc_in = acc_ff;
      if (cmd.wave_rd) begin
         if (step_ff == '0) acc_in = '0;
         else               acc_in = acc_ff + SW'(rd_a_s) + SW'(rd_b_s);
      end
   end
   assign quarter = acc_ff >>> 2;
   assign wave_v  = quarter - SW'(rd_a_s);
   assign wave_r  = wave_v - (wave_v >>> 3);

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {front_ff, spot};
      wr_data = wrp_pkg::DROP_RING;
      if (cmd.press_wr) begin
         wr_en   = cell_ok;
         wr_addr = {front_ff, cell_ff[CW-1:0]};
         wr_data = wrp_pkg::PRESS_LEVEL;
      end else if (cmd.drop_wr) begin
         case (step_ff)
            DROP_CENTER: begin
               wr_en   = drop_ok;
               wr_data = wrp_pkg::PRESS_LEVEL;
            end
            DROP_UP: begin
               wr_en   = drop_ok && (row_ff != 3'd0);
               wr_addr = {front_ff, spot - W_C};
            end
            DROP_DOWN: begin
               wr_en   = drop_ok && (32'(row_ff) < wrp_pkg::GRID_HEIGHT - 1);
               wr_addr = {front_ff, spot + W_C};
            end
            DROP_LEFT: begin
               wr_en   = drop_ok && (col_ff != 4'd0);
               wr_addr = {front_ff, spot - 1'b1};
            end
            DROP_RIGHT: begin
               wr_en   = drop_ok && (32'(col_ff) < wrp_pkg::GRID_WIDTH - 1);
               wr_addr = {front_ff, spot + 1'b1};
            end
            default: wr_en = 1'b0;
         endcase
      end else if (cmd.wave_wr) begin
         wr_en   = 1'b1;
         wr_addr = {!front_ff, cnt_ff};
         wr_data = wave_r[7:0];
      end
   end

   // read ports: two neighbors a cycle, back cell on the last step
   always_comb begin
      rd_en     = cmd.rd_issue || cmd.wave_rd;
      rd_a_addr = {front_ff, cell_ff[CW-1:0]};
      rd_b_addr = {!front_ff, cell_ff[CW-1:0]};
      if (cmd.wave_rd) begin
         if (step_ff == wrp_pkg::STEP_LAST) begin
            rd_a_addr = {!front_ff, cnt_ff};
            rd_b_addr = {!front_ff, cnt_ff};
         end else begin
            rd_a_addr = {front_ff, wrp_pkg::nbr_cell(x_ff, y_ff, {step_ff[1:0], 1'b0})};
            rd_b_addr = {front_ff, wrp_pkg::nbr_cell(x_ff, y_ff, {step_ff[1:0], 1'b1})};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) page_mem_ff[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_a_raw_ff <= page_mem_ff[rd_a_addr];
         rd_b_raw_ff <= page_mem_ff[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_a_vld_ff <= 1'b0;
         rd_b_vld_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         if (rd_en) begin
            rd_a_vld_ff <= vld_ff[rd_a_addr];
            rd_b_vld_ff <= vld_ff[rd_b_addr];
         end
      end
   end

   // color terms for a read
   assign blend_sum  = 9'(rd_a_s) + 9'(rd_b_s);
   assign blend_half = blend_sum >>> 1;
   assign h      = !cell_ok ? 8'sd0 : (blend_ff ? blend_half[7:0] : rd_a_s);
   assign half_h = h >>> 1;
   assign mag    = h[7] ? (8'd0 - $unsigned(h)) : $unsigned(h);
   assign inten  = {mag[6:0], 1'b0};
   assign sat    = 8'hff - inten;
   assign bright = inten[7] ? 8'hff : {inten[6:0], 1'b0};
   assign hue    = rainbow_enable ? (hue_cnt_ff + $unsigned(h) + $unsigned(half_h)) : fixed_hue;

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         height_ff <= h;
         inten_ff  <= inten;
         sat_ff    <= sat;
         bright_ff <= bright;
         hue_ff    <= hue;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height     = height_ff;
   assign rsp_intensity  = inten_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;
   assign rsp_hue        = hue_ff;

endmodule

// ----- sv/water_ripple_height_map.sv -----
`timescale 1ns / 1ps
// Top level of the two-page water ripple height map.
//
// Usage notes:
//  - req_* carries one item per handshake (valid high, stall low at the clock
//    edge). req_mode picks press, raindrop, frame tick, read cell or flip.
//  - rsp_* returns one item for each read, in order; no other mode answers.
//  - psel/penable/pwrite/paddr/pwdata: register 0 (addr 0) rainbow_enable,
//    register 1 (addr 4) fixed_hue. pready is tied high. Write only while idle.
//  - Flip and plain tick finish at the accept; press then makes one write,
//    raindrop writes the center and the cells up, down, left and right (one
//    write per cycle on the single page write port), read fills the result
//    register, and tick with run_water sweeps all 70 cells: per cell, eight
//    neighbors plus the old back value over two read ports, then one write.
//  - req_stall is high while an item is in progress; the block takes only one
//    item at a time.
//  - A finished result sits in the output register; new items are accepted
//    while it waits. A read that finishes while rsp_stall holds the previous
//    result waits in its last step until the register frees.
//  - Reset clears both pages (per-entry valid bits, no sweep), the page
//    select, the hue counter and the registers; it is usable the next cycle.
module water_ripple_height_map (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_mode,
   input  logic [6:0]        req_cell_index,
   input  logic [3:0]        req_col,
   input  logic [2:0]        req_row,
   input  logic              req_run_water,
   input  logic              req_blend,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_height,
   output logic [7:0]        rsp_intensity,
   output logic [7:0]        rsp_saturation,
   output logic [7:0]        rsp_brightness,
   output logic [7:0]        rsp_hue,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   wrp_pkg::wrp_cmd_type    cmd;
   wrp_pkg::wrp_status_type status;
   logic                    rainbow_enable;
   logic [7:0]              fixed_hue;

   wrp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .rainbow_enable (rainbow_enable),
      .fixed_hue      (fixed_hue)
   );

   // controller: decodes the accepted item and steps through its work
   wrp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_run_water (req_run_water),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: page memory, counters, wave math, result register
   wrp_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cell_index (req_cell_index),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_blend      (req_blend),
      .rainbow_enable (rainbow_enable),
      .fixed_hue      (fixed_hue),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_height     (rsp_height),
      .rsp_intensity  (rsp_intensity),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_hue        (rsp_hue)
   );

endmodule

// ----- sv/wrp_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the water ripple height map, bound to the top level.
module wrp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [2:0]        req_mode,
   input logic              req_run_water,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_height,
   input logic [7:0]        rsp_hue
);

   logic acc_read;
   logic acc_press;
   logic acc_quick;

   assign acc_read  = req_valid && !req_stall && (req_mode == wrp_pkg::MODE_READ);
   assign acc_press = req_valid && !req_stall && (req_mode == wrp_pkg::MODE_PRESS);
   assign acc_quick = req_valid && !req_stall &&
                      ((req_mode == wrp_pkg::MODE_FLIP) ||
                       ((req_mode == wrp_pkg::MODE_TICK) && !req_run_water));

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_height) && $stable(rsp_hue))
      else $error("stalled result changed");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(acc_read, 3))
      else $error("result appeared without a read item three cycles earlier");

   a_press_busy: assert property (@(posedge clock) disable iff (reset)
      acc_press |=> req_stall)
      else $error("press item did not occupy the block");

   a_quick_items: assert property (@(posedge clock) disable iff (reset)
      acc_quick |=> !req_stall)
      else $error("flip or plain tick held off the next item");

endmodule

bind water_ripple_height_map wrp_checker u_wrp_checker (.*);
